### hw/rtl/hsr_pkg.sv
package hsr_pkg;

	// default shape of the radicand
	localparam int RADICAND_BITS_DEF = 32;
	localparam int FRACTION_BITS_DEF = 16;

	// fixed width of the root field
	localparam int ROOT_WIDTH = 24;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIVIDE,
		ST_UPDATE,
		ST_HOLD
	} hsr_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture radicand, set start estimate
		logic div_start;   // clear remainder and quotient, load numerator and bit count
		logic div_step;    // one restoring divide step
		logic x_update;    // take the new estimate
		logic result_load; // move the estimate into the output register
	} hsr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic x_zero;    // estimate is zero, nothing to iterate
		logic div_last;  // current divide step is the last one
		logic converged; // new estimate is not below the current one
	} hsr_status_t;

endpackage

### hw/rtl/hsr_ctrl.sv
module hsr_ctrl
	import hsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  hsr_status_t status,
	output hsr_cmd_t    cmd
);

	hsr_state_t state_q;
	hsr_state_t state_next;
	logic       out_valid_q;
	logic       out_free;

	// output slot is free when empty or being drained this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_START;
			end
			ST_START: begin
				if (status.x_zero) state_next = ST_HOLD;
				else state_next = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (status.div_last) state_next = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (status.converged) state_next = ST_HOLD;
				else state_next = ST_START;
			end
			ST_HOLD: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load        = in_valid;
			ST_START:  cmd.div_start   = !status.x_zero;
			ST_DIVIDE: cmd.div_step    = 1'b1;
			ST_UPDATE: cmd.x_update    = !status.converged;
			ST_HOLD:   cmd.result_load = out_free;
			default:   cmd = '0;
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.result_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

### hw/rtl/hsr_datapath.sv
module hsr_datapath
	import hsr_pkg::*;
#(
	parameter int RADICAND_BITS = RADICAND_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic [RADICAND_BITS-1:0] radicand,
	input  hsr_cmd_t                 cmd,
	output hsr_status_t              status,
	output logic [ROOT_WIDTH-1:0]    root
);

	localparam int NUM_BITS = RADICAND_BITS + FRACTION_BITS;
	localparam int XW = (RADICAND_BITS > FRACTION_BITS) ? RADICAND_BITS : FRACTION_BITS + 1;
	localparam int CW = $clog2(NUM_BITS);

	logic [RADICAND_BITS-1:0] r_q;
	logic [XW-1:0]            x_q;
	logic [XW-1:0]            rem_q;
	logic [NUM_BITS-1:0]      quo_q;
	logic [NUM_BITS-1:0]      num_q;
	logic [CW-1:0]            cnt_q;
	logic [ROOT_WIDTH-1:0]    root_q;

	logic [XW-1:0]       one;
	logic [XW-1:0]       r_ext;
	logic [XW-1:0]       x_init;
	logic [XW:0]         rem_sh;
	logic                fits;
	logic [XW:0]         rem_sub;
	logic [NUM_BITS:0]   sum;
	logic [NUM_BITS-1:0] nx;

	// start estimate: radicand, or 1.0 below 1.0, zero for a zero radicand
	assign one   = XW'(1) << FRACTION_BITS;
	assign r_ext = XW'(radicand);
	always_comb begin
		if (radicand == '0) x_init = '0;
		else if (r_ext >= one) x_init = r_ext;
		else x_init = one;
	end

	// restoring divide step on the numerator shift line
	assign rem_sh  = {rem_q, num_q[NUM_BITS-1]};
	assign fits    = (rem_sh >= {1'b0, x_q});
	assign rem_sub = rem_sh - {1'b0, x_q};

	// heron update (x + q) / 2
	assign sum = (NUM_BITS + 1)'(x_q) + {1'b0, quo_q};
	assign nx  = sum[NUM_BITS:1];

	assign status.x_zero    = (x_q == '0);
	assign status.div_last  = (cnt_q == '0);
	assign status.converged = (nx >= NUM_BITS'(x_q));
	assign root             = root_q;

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q <= radicand;
			x_q <= x_init;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= '0;
			num_q <= NUM_BITS'(r_q) << FRACTION_BITS;
			cnt_q <= CW'(NUM_BITS - 1);
		end
		if (cmd.div_step) begin
			rem_q <= fits ? rem_sub[XW-1:0] : rem_sh[XW-1:0];
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
			num_q <= num_q << 1;
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.x_update) x_q <= nx[XW-1:0];
		if (cmd.result_load) root_q <= ROOT_WIDTH'(x_q);
	end

endmodule

### hw/rtl/heron_square_root_unit.sv
// each heron iteration passes through ST_START, ST_DIVIDE and ST_UPDATE, with ST_DIVIDE
//   running the restoring divider at one quotient bit per cycle
// one radicand at a time: in_stall stays high until the root has been moved into the
//   output register
// a zero radicand goes from ST_START straight to ST_HOLD, skipping the divider
// reset: arst_n asynchronous active low clears the controller and the output valid
module heron_square_root_unit
	import hsr_pkg::*;
#(
	parameter int RADICAND_BITS = RADICAND_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [RADICAND_BITS-1:0] radicand,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ROOT_WIDTH-1:0]    root
);

	hsr_cmd_t    cmd;
	hsr_status_t status;

	// sequencer
	hsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// estimate, divider and output register
	hsr_datapath #(
		.RADICAND_BITS (RADICAND_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk      (clk),
		.radicand (radicand),
		.cmd      (cmd),
		.status   (status),
		.root     (root)
	);

endmodule

### tb/sv/heron_square_root_unit_test.sv
module heron_square_root_unit_test
	import hsr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BEATS  = 750;
	localparam int CALM_BEATS    = 100;
	localparam int PAUSE_AT_BEAT = 400;
	localparam int HOLDOFF_AFTER = 120;
	localparam int HOLDOFF_LEN   = 4000;
	localparam int DRAIN_CYCLES  = 1000;
	localparam int LIMIT_CYCLES  = 3000000;
	localparam logic [31:0] ONE_Q = 32'h1 << FRACTION_BITS_DEF;

	// directed probe: radicand, whether the root is typed in, the typed root
	typedef struct packed {
		logic [31:0]           radicand;
		logic                  typed;
		logic [ROOT_WIDTH-1:0] root;
	} probe_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [RADICAND_BITS_DEF-1:0] radicand = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [ROOT_WIDTH-1:0]        root;

	logic [ROOT_WIDTH-1:0] pending_roots [$];
	int                    mismatches = 0;
	int                    roots_seen = 0;
	int                    cycle_count = 0;
	bit                    calm = 1'b0;

	probe_t probes [0:16] = '{
		'{32'h0000_0000, 1'b1, 24'h00_0000},  // zero radicand
		'{32'h0000_0001, 1'b1, 24'h00_0100},  // smallest nonzero
		'{32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF},  // largest radicand
		'{32'h0001_0000, 1'b1, 24'h01_0000},  // exactly one
		'{32'h0000_4000, 1'b1, 24'h00_8000},  // a quarter
		'{32'h0004_0000, 1'b1, 24'h02_0000},
		'{32'h0019_0000, 1'b1, 24'h05_0000},
		'{32'h0100_0000, 1'b1, 24'h10_0000},
		'{32'h0000_FFFF, 1'b0, 24'h00_0000},  // just below one
		'{32'h0001_0001, 1'b0, 24'h00_0000},
		'{32'h0018_FFFF, 1'b0, 24'h00_0000},
		'{32'h8000_0000, 1'b0, 24'h00_0000},
		'{32'h7FFF_FFFF, 1'b0, 24'h00_0000},
		'{32'hAAAA_AAAA, 1'b0, 24'h00_0000},
		'{32'h5555_5555, 1'b0, 24'h00_0000},
		'{32'h0000_0002, 1'b0, 24'h00_0000},
		'{32'hFFFF_0000, 1'b0, 24'h00_0000}
	};

	heron_square_root_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.radicand  (radicand),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.root      (root)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// heron iteration on integers, stopping once the estimate stops falling
	function automatic logic [ROOT_WIDTH-1:0] heron_root_of(input logic [31:0] r);
		logic [63:0] num;
		logic [63:0] x;
		logic [63:0] q;
		logic [63:0] nx;
		if (r == '0)
			return '0;
		num = {16'h0, r, 16'h0};
		x = (r >= ONE_Q) ? {32'h0, r} : {32'h0, ONE_Q};
		while (1'b1) begin
			q = num / x;
			nx = (x + q) >> 1;
			if (nx >= x)
				break;
			x = nx;
		end
		return x[ROOT_WIDTH-1:0];
	endfunction

	// random radicand, weighted toward edges of the root function
	function automatic logic [31:0] pick_radicand();
		logic [31:0] m;
		int          kind;
		kind = $urandom_range(0, 9);
		m = $urandom_range(1, 65535);
		case (kind)
			0, 1, 2: return $urandom;
			3: return $urandom_range(0, 32'h0000_FFFF);
			4: return $urandom & 32'h00FF_FFFF;
			5, 6: return m * m + $urandom_range(0, 2) - 1;
			7: return 32'h1 << $urandom_range(0, 31);
			8: return ~(32'h1 << $urandom_range(0, 31));
			default: return ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, 255);
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// offer one beat, then maybe leave a short gap
	task automatic send_beat(input logic [31:0] value, input logic typed,
			input logic [ROOT_WIDTH-1:0] typed_root);
		int gap;
		in_valid <= 1'b1;
		radicand <= value;
		do @(posedge clk); while (in_stall);
		pending_roots.push_back(typed ? typed_root : heron_root_of(value));
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side: check each beat, stall in bursts, one long hold-off
	initial begin
		int  burst;
		bit  held;
		logic [ROOT_WIDTH-1:0] want;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_roots.size() == 0) begin
					report_mismatch($sformatf("root %h with nothing pending", root));
				end else begin
					want = pending_roots.pop_front();
					if (root !== want)
						report_mismatch($sformatf("root expected %h got %h", want, root));
				end
				roots_seen++;
			end
			if (!held && roots_seen == HOLDOFF_AFTER) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLDOFF_LEN) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 3);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// reset, directed table, random beats, drain
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i])
			send_beat(probes[i].radicand, probes[i].typed, probes[i].root);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i == RANDOM_BEATS - CALM_BEATS)
				calm = 1'b1;
			if (i == PAUSE_AT_BEAT) begin
				// sender waits until every root is back
				in_valid <= 1'b0;
				while (pending_roots.size() != 0) @(posedge clk);
			end
			send_beat(pick_radicand(), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_roots.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/hsr_pkg.sv
hw/rtl/hsr_ctrl.sv
hw/rtl/hsr_datapath.sv
hw/rtl/heron_square_root_unit.sv
tb/sv/heron_square_root_unit_test.sv
